FILE: design/rbbz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbbz_pkg
// shared widths, register indexes and control types of the rolling band block
// ----------------------------------------------------------------------------
package rbbz_pkg;

  // fixed field widths
  localparam int PRICE_BITS = 24;
  localparam int SYM_IN_W   = 8;
  localparam int DAY_W      = 32;
  localparam int DAY_OUT_W  = 31;
  localparam int WL_W       = 7;
  localparam int MULT_W     = 12;
  localparam int Z_W        = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MULTIPLIER = 1'b1;

  // reset values of the registers
  localparam logic [WL_W-1:0]   WL_RESET   = 7'd20;
  localparam logic [MULT_W-1:0] MULT_RESET = 12'd512;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // control from the register file to the front
  typedef struct packed {
    logic clear;   // drop every symbol window
    logic enable;  // multiplier non-zero
  } fr_ctl_t;

endpackage
`default_nettype wire

FILE: design/rbbz_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbbz_queue
// small first-in first-out queue of finished window updates
// ----------------------------------------------------------------------------
module rbbz_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: design/rbbz_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbbz_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbbz_div #(
  parameter int DW = 33,
  parameter int VW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   rem_sh, rem_sub;
  logic          fits;

  // trial subtract of the shifted remainder
  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign fits     = (rem_sh >= {1'b0, dvs_r});
  assign busy     = busy_r;
  assign quotient = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

FILE: design/rbbz_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbbz_front
// filters bars and updates the per-symbol ring, sum and sum of squares
// ----------------------------------------------------------------------------
module rbbz_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_WINDOW   = 64,
  parameter int LEN_W        = 7,
  parameter int SUM_W        = 30,
  parameter int SQ_W         = 54,
  parameter int QW           = 147
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [rbbz_pkg::SYM_IN_W-1:0]    in_symbol_index,
  input  wire logic [rbbz_pkg::PRICE_BITS-1:0]  in_close_price,
  input  wire logic [rbbz_pkg::DAY_W-1:0]       in_trading_day,
  input  wire logic                             in_bar_valid,
  input  wire rbbz_pkg::fr_ctl_t                ctl,
  input  wire logic [LEN_W-1:0]                 len,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output logic [QW-1:0]                         q_data
);
  import rbbz_pkg::*;

  localparam int SYM_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CUR_W      = $clog2(MAX_WINDOW);
  localparam int RING_DEPTH = SYMBOL_COUNT * MAX_WINDOW;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int ST_W       = LEN_W + CUR_W + SUM_W + SQ_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD   = 2'd1;
  localparam logic [1:0] F_OLD  = 2'd2;
  localparam logic [1:0] F_WR   = 2'd3;

  logic [ST_W-1:0]         st_mem [SYMBOL_COUNT];
  logic [PRICE_BITS-1:0]   ring_mem [RING_DEPTH];
  logic [SYMBOL_COUNT-1:0] vld_r;

  logic [1:0]              state_r, state_nxt;
  logic [SYM_W-1:0]        sym_r;
  logic [SYM_IN_W-1:0]     sym8_r;
  logic [PRICE_BITS-1:0]   price_r, ring_q_r, old_r;
  logic [DAY_OUT_W-1:0]    day_r;
  logic [ST_W-1:0]         st_q_r;
  logic                    vld_q_r;
  logic [2*PRICE_BITS-1:0] psq_r, osq_r;

  logic [SYM_W-1:0]        in_sym;
  logic                    accept, drop;
  logic [ST_W-1:0]         st_cur;
  logic [LEN_W-1:0]        fill, new_fill, cur_p1;
  logic [CUR_W-1:0]        cur, new_cur, slot;
  logic [SUM_W-1:0]        sum, new_sum;
  logic [SQ_W-1:0]         sq, new_sq;
  logic                    full_now, emit, leave_wr;
  logic [RING_AW-1:0]      ring_addr;
  logic [PRICE_BITS-1:0]   old_val;

  // input filter
  assign in_sym  = SYM_W'(in_symbol_index);
  assign drop    = !in_bar_valid || in_trading_day[DAY_W-1]
                || (32'(in_symbol_index) >= SYMBOL_COUNT)
                || (len == '0) || !ctl.enable;
  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;

  // symbol record, zero until first written after a clear
  assign st_cur = vld_q_r ? st_q_r : '0;
  assign fill   = st_cur[ST_W-1 -: LEN_W];
  assign cur    = st_cur[SUM_W+SQ_W +: CUR_W];
  assign sum    = st_cur[SQ_W +: SUM_W];
  assign sq     = st_cur[SQ_W-1:0];

  assign full_now  = (fill == len);
  assign slot      = full_now ? cur : fill[CUR_W-1:0];
  assign ring_addr = RING_AW'(sym_r * MAX_WINDOW) + RING_AW'(slot);
  assign old_val   = full_now ? ring_q_r : '0;

  // updated record
  assign new_sum  = sum - SUM_W'(old_r) + SUM_W'(price_r);
  assign new_sq   = sq - SQ_W'(osq_r) + SQ_W'(psq_r);
  assign new_fill = full_now ? fill : fill + 1'b1;
  assign cur_p1   = LEN_W'(cur) + 1'b1;
  assign new_cur  = !full_now ? cur : ((cur_p1 == len) ? '0 : cur_p1[CUR_W-1:0]);
  assign emit     = (new_fill == len);
  assign leave_wr = !(emit && q_full);

  assign q_push = (state_r == F_WR) && emit && !q_full;
  assign q_data = {sym8_r, price_r, day_r, new_sum, new_sq};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept && !drop) state_nxt = F_RD;
      F_RD:   state_nxt = F_OLD;
      F_OLD:  state_nxt = F_WR;
      F_WR:   if (leave_wr) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (state_r == F_WR && leave_wr) begin
        vld_r[sym_r] <= 1'b1;
      end
    end
  end

  // bar capture and record read, a clear in the same cycle wins
  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r   <= in_sym;
      sym8_r  <= in_symbol_index;
      price_r <= in_close_price;
      day_r   <= in_trading_day[DAY_OUT_W-1:0];
      st_q_r  <= st_mem[in_sym];
      vld_q_r <= vld_r[in_sym] && !ctl.clear;
    end
  end

  // ring read and squares
  always_ff @(posedge clk) begin
    if (state_r == F_RD) begin
      ring_q_r <= ring_mem[ring_addr];
      psq_r    <= price_r * price_r;
    end
    if (state_r == F_OLD) begin
      old_r <= old_val;
      osq_r <= old_val * old_val;
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (state_r == F_WR && leave_wr) begin
      st_mem[sym_r]       <= {new_fill, new_cur, new_sum, new_sq};
      ring_mem[ring_addr] <= price_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/rbbz_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbbz_back
// mean, deviation, bands and z-score from a finished window update
// ----------------------------------------------------------------------------
module rbbz_back #(
  parameter int LEN_W = 7,
  parameter int SUM_W = 30,
  parameter int SQ_W  = 54,
  parameter int QW    = 147
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  input  wire logic [QW-1:0]                     q_data,
  input  wire logic [LEN_W-1:0]                  len,
  input  wire logic [rbbz_pkg::MULT_W-1:0]       mult,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic [rbbz_pkg::SYM_IN_W-1:0]          out_symbol_out,
  output logic [rbbz_pkg::PRICE_BITS-1:0]        out_close_out,
  output logic [rbbz_pkg::PRICE_BITS-1:0]        out_middle_band,
  output logic [rbbz_pkg::PRICE_BITS:0]          out_upper_band,
  output logic signed [rbbz_pkg::PRICE_BITS:0]   out_lower_band,
  output logic [rbbz_pkg::PRICE_BITS-1:0]        out_std_deviation,
  output logic signed [rbbz_pkg::Z_W-1:0]        out_z_score,
  output logic [rbbz_pkg::DAY_OUT_W-1:0]         out_day_out
);
  import rbbz_pkg::*;

  localparam int P      = PRICE_BITS;
  localparam int RAD_W0 = SQ_W + LEN_W;
  localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int SQC_W  = $clog2(ROOT_W + 1);
  localparam int DA     = SUM_W + 1;
  localparam int DB     = (ROOT_W > DA) ? ROOT_W : DA;
  localparam int DW     = ((P + 9) > DB) ? (P + 9) : DB;
  localparam int VW     = (LEN_W > P) ? LEN_W : P;
  localparam int PR_W   = MULT_W + P;
  localparam int OFF_W  = PR_W + 1 - 8;
  localparam int LW     = OFF_W + 2;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_MUL  = 4'd1;
  localparam logic [3:0] B_RAD  = 4'd2;
  localparam logic [3:0] B_SQRT = 4'd3;
  localparam logic [3:0] B_MEAN = 4'd4;
  localparam logic [3:0] B_SD   = 4'd5;
  localparam logic [3:0] B_OFF  = 4'd6;
  localparam logic [3:0] B_BAND = 4'd7;
  localparam logic [3:0] B_Z    = 4'd8;
  localparam logic [3:0] B_OUT  = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [SYM_IN_W-1:0]  sym_r;
  logic [P-1:0]         price_r, mean_r, sd_r;
  logic [DAY_OUT_W-1:0] day_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SQ_W-1:0]      sq_r;
  logic [2*SUM_W-1:0]   ssq_r;
  logic [RAD_W-1:0]     lsq_r, rad_r;
  logic [ROOT_W+1:0]    rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [SQC_W-1:0]     sqc_r;
  logic [PR_W-1:0]      prod_r;
  logic [P:0]           upper_r;
  logic signed [P:0]    lower_r;
  logic                 neg_r;
  logic [Z_W-1:0]       z_r;

  logic                 div_start, div_busy;
  logic [DW-1:0]        div_a, div_q;
  logic [VW-1:0]        div_b;
  logic [ROOT_W+3:0]    rem_sh, trial, sq_rem;
  logic                 sq_fits;
  logic [PR_W:0]        prnd;
  logic [OFF_W-1:0]     off;
  logic [OFF_W:0]       up_sum;
  logic signed [LW-1:0] lw, lo_min;
  logic signed [P+1:0]  diff, diff_neg;
  logic [P:0]           mag;
  logic [P-1:0]         den;
  logic [16:0]          qc, qn;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_empty = (state_r != B_OUT);

  // square root step, two radicand bits a cycle
  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sq_fits = (rem_sh >= trial);
  assign sq_rem  = rem_sh - trial;

  // band offset with round half up
  assign prnd   = {1'b0, prod_r} + (PR_W+1)'(128);
  assign off    = prnd[PR_W:8];
  assign up_sum = (OFF_W+1)'(mean_r) + {1'b0, off};
  assign lw     = $signed(LW'(mean_r)) - $signed(LW'(off));
  assign lo_min = {{(LW-P){1'b1}}, {P{1'b0}}};

  // signed distance of the close from the mean
  assign diff     = $signed({2'b00, price_r}) - $signed({2'b00, mean_r});
  assign diff_neg = -diff;
  assign mag      = diff[P+1] ? diff_neg[P:0] : diff[P:0];
  assign den      = (sd_r == '0) ? P'(1) : sd_r;

  // z-score saturation
  assign qc = (div_q > DW'(32768)) ? 17'd32768 : div_q[16:0];
  assign qn = -qc;

  // shared divider operands
  always_comb begin
    div_start = 1'b0;
    div_a     = DW'(sum_r) + DW'(len >> 1);
    div_b     = VW'(len);
    unique case (state_r)
      B_RAD:  div_start = 1'b1;
      B_MEAN: begin
        div_start = !div_busy;
        div_a     = DW'(root_r);
      end
      B_BAND: begin
        div_start = 1'b1;
        div_a     = DW'({mag, 8'h00});
        div_b     = VW'(den);
      end
      default: div_start = 1'b0;
    endcase
  end

  rbbz_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_RAD;
      B_RAD:  state_nxt = B_SQRT;
      B_SQRT: if (sqc_r == SQC_W'(ROOT_W - 1)) state_nxt = B_MEAN;
      B_MEAN: if (!div_busy) state_nxt = B_SD;
      B_SD:   if (!div_busy) state_nxt = B_OFF;
      B_OFF:  state_nxt = B_BAND;
      B_BAND: state_nxt = B_Z;
      B_Z:    if (!div_busy) state_nxt = B_OUT;
      B_OUT:  if (out_pop) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        {sym_r, price_r, day_r, sum_r, sq_r} <= q_data;
      end
      B_MUL: begin
        ssq_r <= sum_r * sum_r;
        lsq_r <= len * sq_r;
      end
      B_RAD: begin
        rad_r  <= (lsq_r > RAD_W'(ssq_r)) ? lsq_r - RAD_W'(ssq_r) : '0;
        rem_r  <= '0;
        root_r <= '0;
        sqc_r  <= '0;
      end
      B_SQRT: begin
        rad_r  <= rad_r << 2;
        sqc_r  <= sqc_r + 1'b1;
        rem_r  <= sq_fits ? sq_rem[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], sq_fits};
      end
      B_MEAN: begin
        if (!div_busy) mean_r <= div_q[P-1:0];
      end
      B_SD: begin
        if (!div_busy) sd_r <= (div_q > DW'({P{1'b1}})) ? {P{1'b1}} : div_q[P-1:0];
      end
      B_OFF: begin
        prod_r <= mult * sd_r;
      end
      B_BAND: begin
        upper_r <= (up_sum[OFF_W:P+1] != '0) ? {(P+1){1'b1}} : up_sum[P:0];
        lower_r <= (lw < lo_min) ? lo_min[P:0] : lw[P:0];
        neg_r   <= diff[P+1];
      end
      B_Z: begin
        if (neg_r) begin
          z_r <= qn[Z_W-1:0];
        end else begin
          z_r <= qc[16] ? 16'h7FFF : qc[Z_W-1:0];
        end
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // result ports
  assign out_symbol_out    = sym_r;
  assign out_close_out     = price_r;
  assign out_middle_band   = mean_r;
  assign out_upper_band    = upper_r;
  assign out_lower_band    = lower_r;
  assign out_std_deviation = sd_r;
  assign out_z_score       = z_r;
  assign out_day_out       = day_r;

endmodule
`default_nettype wire

FILE: design/rolling_bollinger_band_zscore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_bollinger_band_zscore
// per-symbol rolling mean, deviation, bands and z-score of close prices
//
//   channel   handshake          accepted when         carries
//   in_       in_push / in_full  in_push & !in_full    one price bar
//   out_      out_empty/out_pop  out_pop & !out_empty  one band result
//   cfg_      cfg_valid/ready    cfg_valid & ready     register index, data
//
// the front takes a bar through record read, ring read and squaring, old-value
// squaring and write back, waiting there while a due update meets a full queue
// (a dropped bar skips these steps); the back's pace up to its wait on out_pop
// is set by the shared one-bit-a-cycle divider (three 33-step divisions)
// and the 31-step square root, which runs alongside the first division
// a two-entry request queue between them lets the front keep taking bars
// reset clears per-symbol valid flags at once, no clearing pass is run
// ----------------------------------------------------------------------------
module rolling_bollinger_band_zscore #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_WINDOW   = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire logic [rbbz_pkg::SYM_IN_W-1:0]      in_symbol_index,
  input  wire logic [rbbz_pkg::PRICE_BITS-1:0]    in_close_price,
  input  wire logic signed [rbbz_pkg::DAY_W-1:0]  in_trading_day,
  input  wire logic                               in_bar_valid,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output logic [rbbz_pkg::SYM_IN_W-1:0]           out_symbol_out,
  output logic [rbbz_pkg::PRICE_BITS-1:0]         out_close_out,
  output logic [rbbz_pkg::PRICE_BITS-1:0]         out_middle_band,
  output logic [rbbz_pkg::PRICE_BITS:0]           out_upper_band,
  output logic signed [rbbz_pkg::PRICE_BITS:0]    out_lower_band,
  output logic [rbbz_pkg::PRICE_BITS-1:0]         out_std_deviation,
  output logic signed [rbbz_pkg::Z_W-1:0]         out_z_score,
  output logic [rbbz_pkg::DAY_OUT_W-1:0]          out_day_out,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rbbz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rbbz_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rbbz_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int SQ_W  = 2 * PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int QW    = SYM_IN_W + PRICE_BITS + DAY_OUT_W + SUM_W + SQ_W;

  logic [WL_W-1:0]   wl_r;
  logic [MULT_W-1:0] mult_r;
  logic              clear_r;
  logic [LEN_W-1:0]  len;
  fr_ctl_t           ctl;
  logic              cfg_wr;
  logic              q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]     q_wdata, q_rdata;

  // register file
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r    <= WL_RESET;
      mult_r  <= MULT_RESET;
      clear_r <= 1'b0;
    end else begin
      clear_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH: begin
            wl_r    <= cfg_data[WL_W-1:0];
            clear_r <= 1'b1;
          end
          REG_BAND_MULTIPLIER: mult_r <= cfg_data[MULT_W-1:0];
          default: clear_r <= 1'b0;
        endcase
      end
    end
  end

  // window length limited to the ring size
  assign len        = (32'(wl_r) > MAX_WINDOW) ? LEN_W'(MAX_WINDOW) : LEN_W'(wl_r);
  assign ctl.clear  = clear_r;
  assign ctl.enable = (mult_r != '0);

  rbbz_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_WINDOW   (MAX_WINDOW),
    .LEN_W        (LEN_W),
    .SUM_W        (SUM_W),
    .SQ_W         (SQ_W),
    .QW           (QW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_symbol_index (in_symbol_index),
    .in_close_price  (in_close_price),
    .in_trading_day  (in_trading_day),
    .in_bar_valid    (in_bar_valid),
    .ctl             (ctl),
    .len             (len),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  rbbz_queue #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  rbbz_back #(
    .LEN_W (LEN_W),
    .SUM_W (SUM_W),
    .SQ_W  (SQ_W),
    .QW    (QW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .len               (len),
    .mult              (mult_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_symbol_out    (out_symbol_out),
    .out_close_out     (out_close_out),
    .out_middle_band   (out_middle_band),
    .out_upper_band    (out_upper_band),
    .out_lower_band    (out_lower_band),
    .out_std_deviation (out_std_deviation),
    .out_z_score       (out_z_score),
    .out_day_out       (out_day_out)
  );

endmodule
`default_nettype wire

FILE: sim/rolling_bollinger_band_zscore_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_bollinger_band_zscore_test
// self-checking bench for the rolling band and z-score block
//
// a short table of directed bars runs first, then randomised phases of bars
// under several window and multiplier settings, each result compared field by
// field against an in-bench band calculator; both queue sides stall at random
// and the result side is held off once for long enough to back up the input
// ----------------------------------------------------------------------------
module rolling_bollinger_band_zscore_test;
  import rbbz_pkg::*;

  localparam int NSYM = 256;
  localparam int MAXW = 64;
  localparam longint unsigned PMASK = (64'd1 << PRICE_BITS) - 1;
  localparam longint unsigned BMASK = (64'd1 << (PRICE_BITS + 1)) - 1;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [SYM_IN_W-1:0]        sym;
    logic [PRICE_BITS-1:0]      close;
    logic [PRICE_BITS-1:0]      mid;
    logic [PRICE_BITS:0]        upper;
    logic signed [PRICE_BITS:0] lower;
    logic [PRICE_BITS-1:0]      sd;
    logic signed [Z_W-1:0]      z;
    logic [DAY_OUT_W-1:0]       day;
  } band_t;

  typedef enum logic [1:0] {EXP_CALC, EXP_TYPED, EXP_NONE} exp_kind_t;

  typedef struct {
    int              wl;
    int              mult;
    logic [7:0]      sym;
    logic [23:0]     price;
    logic [31:0]     day;
    logic            valid;
    exp_kind_t       kind;
  } row_t;

  logic clk, rst_n;
  logic in_push, in_full;
  logic [SYM_IN_W-1:0] in_symbol_index;
  logic [PRICE_BITS-1:0] in_close_price;
  logic signed [DAY_W-1:0] in_trading_day;
  logic in_bar_valid;
  logic out_empty, out_pop;
  logic [SYM_IN_W-1:0] out_symbol_out;
  logic [PRICE_BITS-1:0] out_close_out, out_middle_band, out_std_deviation;
  logic [PRICE_BITS:0] out_upper_band;
  logic signed [PRICE_BITS:0] out_lower_band;
  logic signed [Z_W-1:0] out_z_score;
  logic [DAY_OUT_W-1:0] out_day_out;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rolling_bollinger_band_zscore u_top (.*);

  // window state held by the band calculator
  logic [23:0]     ring_px [NSYM][MAXW];
  int              filled [NSYM];
  int              cursor [NSYM];
  longint unsigned run_sum [NSYM];
  longint unsigned run_sq [NSYM];
  int              cur_wl, cur_mult;

  band_t expected_bands[$];
  int    errors, bars_sent, bands_seen;
  bit    calm, long_hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint exp_v,
                                 input longint got_v);
    errors++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_windows();
    for (int s = 0; s < NSYM; s++) begin
      filled[s] = 0;
      cursor[s] = 0;
      run_sum[s] = 0;
      run_sq[s] = 0;
    end
  endfunction

  // push one bar into the windows, returns 1 with the band when one is due
  function automatic bit band_update(input logic [7:0] sym, input logic [23:0] px,
                                     input logic [31:0] day, input logic valid,
                                     output band_t r);
    int len, c;
    longint unsigned p, old, mean, rad, sd, ofs, up, den, mag, q;
    longint lo, diff, z;
    r = '0;
    len = cur_wl > MAXW ? MAXW : cur_wl;
    if (!valid || day[31]) return 0;
    if (len == 0 || cur_mult == 0) return 0;
    p = px;
    if (filled[sym] < len) begin
      ring_px[sym][filled[sym]] = px;
      run_sum[sym] += p;
      run_sq[sym] += p * p;
      filled[sym]++;
    end else begin
      c = cursor[sym] % len;
      old = ring_px[sym][c];
      run_sum[sym] = run_sum[sym] - old + p;
      run_sq[sym] = run_sq[sym] - old * old + p * p;
      ring_px[sym][c] = px;
      cursor[sym] = (c + 1) % len;
    end
    if (filled[sym] != len) return 0;
    mean = (run_sum[sym] + len / 2) / len;
    rad = longint'(len) * run_sq[sym];
    rad = rad > run_sum[sym] * run_sum[sym] ? rad - run_sum[sym] * run_sum[sym] : 0;
    sd = int_sqrt(rad) / len;
    if (sd > PMASK) sd = PMASK;
    ofs = (longint'(cur_mult) * sd + 128) >> 8;
    up = mean + ofs;
    if (up > BMASK) up = BMASK;
    lo = longint'(mean) - longint'(ofs);
    if (lo < -(longint'(1) << PRICE_BITS)) lo = -(longint'(1) << PRICE_BITS);
    den = sd > 0 ? sd : 1;
    diff = longint'(p) - longint'(mean);
    mag = diff < 0 ? -diff : diff;
    q = (mag << 8) / den;
    if (q > 32768) q = 32768;
    z = diff < 0 ? -longint'(q) : longint'(q);
    if (z > 32767) z = 32767;
    r.sym = sym;
    r.close = px;
    r.mid = mean[23:0];
    r.upper = up[24:0];
    r.lower = lo[24:0];
    r.sd = sd[23:0];
    r.z = z[15:0];
    r.day = day[30:0];
    return 1;
  endfunction

  // offer one bar until taken, then maybe leave a gap
  task automatic send_bar(input logic [7:0] sym, input logic [23:0] px,
                          input logic [31:0] day, input logic valid,
                          input exp_kind_t kind);
    band_t b;
    bit due;
    in_push <= 1'b1;
    in_symbol_index <= sym;
    in_close_price <= px;
    in_trading_day <= day;
    in_bar_valid <= valid;
    do @(posedge clk); while (in_full);
    bars_sent++;
    due = band_update(sym, px, day, valid, b);
    if (kind == EXP_TYPED) begin
      b = '0;
      b.sym = sym;
      b.close = px;
      b.mid = px;
      b.upper = {1'b0, px};
      b.lower = {1'b0, px};
      b.day = day[30:0];
      expected_bands = {expected_bands, b};
    end else if (kind == EXP_CALC && due) begin
      expected_bands = {expected_bands, b};
    end
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // wait for the block to go idle, then write both registers
  task automatic set_regs(input int wl, input int mult);
    in_push <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    // upper data bits set on purpose; only the low seven count
    cfg_data <= {($urandom_range(0, 1) ? 5'h1F : 5'h00), 7'(wl)};
    do @(posedge clk); while (!cfg_ready);
    cur_wl = wl;
    clear_windows();
    cfg_index <= REG_BAND_MULTIPLIER;
    cfg_data <= 12'(mult);
    do @(posedge clk); while (!cfg_ready);
    cur_mult = mult;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: check each request taken, stall at random
  initial begin : result_side
    int stall, hold;
    band_t e;
    stall = 0;
    hold = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        bands_seen++;
        if (expected_bands.size() == 0) begin
          errors++;
          $display("unexpected result for symbol %0d at %0t", out_symbol_out, $realtime);
        end else begin
          e = expected_bands.pop_front();
          if (out_symbol_out !== e.sym) report_mismatch("symbol", e.sym, out_symbol_out);
          if (out_close_out !== e.close) report_mismatch("close", e.close, out_close_out);
          if (out_middle_band !== e.mid) report_mismatch("middle", e.mid, out_middle_band);
          if (out_upper_band !== e.upper) report_mismatch("upper", e.upper, out_upper_band);
          if (out_lower_band !== e.lower) report_mismatch("lower", e.lower, out_lower_band);
          if (out_std_deviation !== e.sd) report_mismatch("stddev", e.sd, out_std_deviation);
          if (out_z_score !== e.z) report_mismatch("zscore", e.z, out_z_score);
          if (out_day_out !== e.day) report_mismatch("day", e.day, out_day_out);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 2000;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : bar_side
    row_t tbl[$];
    int phase_wl[8]   = '{20, 2, 64, 127, 0, 5, 3, 1};
    int phase_mult[8] = '{512, 4095, 1, 300, 777, 0, 1000, 2048};
    int phase_n[8]    = '{200, 200, 300, 250, 30, 30, 250, 290};
    int phase_sym[8]  = '{4, 16, 2, 2, 8, 8, 8, 256};
    logic [23:0] base;
    logic [23:0] px;
    logic [31:0] day;
    logic [7:0]  sym;
    logic        valid;
    int          sel;

    errors = 0;
    bars_sent = 0;
    bands_seen = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_symbol_index = '0;
    in_close_price = '0;
    in_trading_day = '0;
    in_bar_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW_LENGTH;
    cfg_data = '0;
    cur_wl = WL_RESET;
    cur_mult = MULT_RESET;
    clear_windows();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: one-bar windows give bands equal to the close
    tbl = '{
      '{1, 256, 8'd0,   24'h000000, 32'h0000_0000, 1'b1, EXP_TYPED},
      '{1, 256, 8'd255, 24'hFFFFFF, 32'h7FFF_FFFF, 1'b1, EXP_TYPED},
      '{1, 256, 8'd170, 24'hAAAAAA, 32'h5555_5555, 1'b1, EXP_TYPED},
      '{1, 256, 8'd85,  24'h555555, 32'h2AAA_AAAA, 1'b0, EXP_NONE},
      '{1, 256, 8'd1,   24'h000100, 32'h8000_0000, 1'b1, EXP_NONE},
      '{1, 256, 8'd1,   24'h000100, 32'hFFFF_FFFF, 1'b1, EXP_NONE},
      '{1, 256, 8'd85,  24'h555555, 32'h2AAA_AAAA, 1'b1, EXP_TYPED},
      // wide swings, saturating bands
      '{3, 4095, 8'd7, 24'h000000, 32'd1, 1'b1, EXP_CALC},
      '{3, 4095, 8'd7, 24'hFFFFFF, 32'd2, 1'b1, EXP_CALC},
      '{3, 4095, 8'd7, 24'h000000, 32'd3, 1'b1, EXP_CALC},
      '{3, 4095, 8'd7, 24'hFFFFFF, 32'd4, 1'b1, EXP_CALC},
      // flat window then a one-step move
      '{3, 4095, 8'd9, 24'h001234, 32'd5, 1'b1, EXP_CALC},
      '{3, 4095, 8'd9, 24'h001234, 32'd6, 1'b1, EXP_CALC},
      '{3, 4095, 8'd9, 24'h001234, 32'd7, 1'b1, EXP_CALC},
      '{3, 4095, 8'd9, 24'h001235, 32'd8, 1'b1, EXP_CALC},
      '{3, 4095, 8'd9, 24'hFFFFFF, 32'd9, 1'b1, EXP_CALC},
      // disabled by length, then by multiplier
      '{0, 512, 8'd3, 24'h000005, 32'd10, 1'b1, EXP_NONE},
      '{2, 0,   8'd3, 24'h000005, 32'd11, 1'b1, EXP_NONE},
      '{2, 0,   8'd3, 24'h000006, 32'd12, 1'b1, EXP_NONE},
      // oversized length only starts filling here
      '{127, 1, 8'd4, 24'h000007, 32'd13, 1'b1, EXP_CALC}
    };
    foreach (tbl[i]) begin
      if (i == 0 || tbl[i].wl != cur_wl || tbl[i].mult != cur_mult)
        set_regs(tbl[i].wl, tbl[i].mult);
      send_bar(tbl[i].sym, tbl[i].price, tbl[i].day, tbl[i].valid, tbl[i].kind);
    end

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(phase_wl[ph], phase_mult[ph]);
      calm = (ph == 7);
      if (ph == 0) long_hold_req = 1'b1;
      base = $urandom_range(0, 24'hFFFFFF);
      for (int n = 0; n < phase_n[ph]; n++) begin
        sym = (phase_sym[ph] == 256) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, phase_sym[ph] - 1));
        sel = $urandom_range(0, 99);
        if (sel < 10)      px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        else if (sel < 35) px = $urandom_range(0, 24'hFFFFFF);
        else               px = base + 24'($urandom_range(0, 255));
        day = $urandom() & 32'h7FFF_FFFF;
        valid = 1'b1;
        sel = $urandom_range(0, 99);
        if (sel < 7)       day = $urandom() | 32'h8000_0000;
        else if (sel < 15) valid = 1'b0;
        send_bar(sym, px, day, valid, EXP_CALC);
      end
    end

    // drain and settle
    in_push <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d bars and %0d band results over 8 random settings", bars_sent,
             bands_seen);
    $display("lengths 0 to 127, multipliers 0 to 4095, one long result-side hold");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: rolling_bollinger_band_zscore.f
design/rbbz_pkg.sv
design/rbbz_queue.sv
design/rbbz_div.sv
design/rbbz_front.sv
design/rbbz_back.sv
design/rolling_bollinger_band_zscore.sv
sim/rolling_bollinger_band_zscore_test.sv
